@@ src/pse_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Postfix evaluator package
// Shared sizes, character codes, operator and error codes, port structs.
// ---------------------------------------------------------------------------
package pse_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int FRAC_BITS   = 16;

   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int NUM_W  = WORD_W + FRAC_BITS;
   localparam int ITER_W = $clog2(NUM_W);

   localparam logic [7:0] CH_ZERO = 8'd48;
   localparam logic [7:0] CH_NINE = 8'd57;
   localparam logic [7:0] CH_ADD  = 8'h2B;
   localparam logic [7:0] CH_SUB  = 8'h2D;
   localparam logic [7:0] CH_MUL  = 8'h2A;
   localparam logic [7:0] CH_DIV  = 8'h2F;

   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_UNDER = 3'd1,
      ERR_BADCH = 3'd2,
      ERR_LEFT  = 3'd3,
      ERR_DIV0  = 3'd4,
      ERR_OVER  = 3'd5
   } err_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } stk_req_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_cmd_type;

endpackage

@@ src/postfix_stack_evaluator_top.sv @@
`timescale 1ns / 1ps
// A digit is pushed in S_IDLE; req_ready stays high unless it was last.
// + - * / (Q16.16) read two stack entries, in S_RD1 and S_RD2, then run
// the serial ALU at one bit per cycle; a zero divisor stops / in S_RD1.
// A last word goes on through S_FIN and S_OUT to the result on rsp_*.
// Synchronous active-high reset empties the stack and clears the error.
// ---------------------------------------------------------------------------
// Postfix stack evaluator
// Evaluates a postfix expression, one character word at a time, in signed
// fixed point with a sticky error code reported on the last word.
// ---------------------------------------------------------------------------
module postfix_stack_evaluator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic               rsp_ok,
   output logic [2:0]         rsp_error_code
);
   import pse_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_EXEC,
      S_FIN,
      S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   err_type           err_ff, err_in;
   op_type            op_ff, op_in;
   logic              last_ff, last_in;
   logic [WORD_W-1:0] opb_ff, opb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_ok_ff, rsp_ok_in;
   err_type           rsp_code_ff, rsp_code_in;

   stk_req_type       stk;
   alu_cmd_type       alu_cmd;
   logic [WORD_W-1:0] rd_data;
   logic              alu_done;
   logic [WORD_W-1:0] alu_result;

   logic              is_digit;
   logic [CNT_W-1:0]  cnt_m1, cnt_m2;
   state_type         tail_idle, tail_last;

   pse_stack u_stack (
      .clock   (clock),
      .req     (stk),
      .rd_data (rd_data)
   );

   pse_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .a      (rd_data),
      .b      (opb_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      opb_in       = opb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_code_in  = rsp_code_ff;
      stk          = '0;
      alu_cmd      = '0;

      is_digit  = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
      cnt_m1    = count_ff - CNT_W'(1);
      cnt_m2    = count_ff - CNT_W'(2);
      tail_idle = req_last ? S_FIN : S_IDLE;
      tail_last = last_ff ? S_FIN : S_IDLE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               last_in  = req_last;
               state_in = tail_idle;
               if (err_ff != ERR_NONE) begin
                  state_in = tail_idle;
               end else if (is_digit) begin
                  if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     err_in = ERR_OVER;
                  end else begin
                     stk.we    = 1'b1;
                     stk.waddr = count_ff[ADDR_W-1:0];
                     stk.wdata = WORD_W'(req_ch[3:0]) << FRAC_BITS;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end else if (count_ff < CNT_W'(2)) begin
                  err_in = ERR_UNDER;
               end else begin
                  stk.raddr = cnt_m1[ADDR_W-1:0];
                  unique case (req_ch)
                     CH_ADD: begin
                        op_in    = OP_ADD;
                        stk.re   = 1'b1;
                        state_in = S_RD1;
                     end
                     CH_SUB: begin
                        op_in    = OP_SUB;
                        stk.re   = 1'b1;
                        state_in = S_RD1;
                     end
                     CH_MUL: begin
                        op_in    = OP_MUL;
                        stk.re   = 1'b1;
                        state_in = S_RD1;
                     end
                     CH_DIV: begin
                        op_in    = OP_DIV;
                        stk.re   = 1'b1;
                        state_in = S_RD1;
                     end
                     default: err_in = ERR_BADCH;
                  endcase
               end
            end
         end
         S_RD1: begin
            opb_in = rd_data;
            if (op_ff == OP_DIV && rd_data == '0) begin
               err_in   = ERR_DIV0;
               state_in = tail_last;
            end else begin
               stk.re    = 1'b1;
               stk.raddr = cnt_m2[ADDR_W-1:0];
               state_in  = S_RD2;
            end
         end
         S_RD2: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = op_ff;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            if (alu_done) begin
               stk.we    = 1'b1;
               stk.waddr = cnt_m2[ADDR_W-1:0];
               stk.wdata = alu_result;
               count_in  = cnt_m1;
               state_in  = tail_last;
            end
         end
         S_FIN: begin
            stk.re    = 1'b1;
            stk.raddr = '0;
            if (err_ff == ERR_NONE) begin
               if (count_ff == '0) begin
                  err_in = ERR_UNDER;
               end else if (count_ff > CNT_W'(1)) begin
                  err_in = ERR_LEFT;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = (err_ff == ERR_NONE) ? rd_data : '0;
               rsp_ok_in    = (err_ff == ERR_NONE);
               rsp_code_in  = err_ff;
               count_in     = '0;
               err_in       = ERR_NONE;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      last_ff      <= last_in;
      opb_ff       <= opb_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_code_ff  <= rsp_code_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = $signed(rsp_value_ff);
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_error_code = rsp_code_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == S_EXEC)
      else $error("alu result outside execute");

   assert property (@(posedge clock) disable iff (reset)
      stk.we |-> err_ff == ERR_NONE)
      else $error("stack write with sticky error");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff |-> rsp_code_ff == ERR_NONE)
      else $error("ok word carries an error code");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD2 |=> state_ff == S_EXEC)
      else $error("operand fetch did not start alu");

endmodule

@@ src/pse_stack.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Operand stack memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pse_stack (
   input  logic                      clock,
   input  pse_pkg::stk_req_type      req,
   output logic [pse_pkg::WORD_W-1:0] rd_data
);
   import pse_pkg::*;

   logic [WORD_W-1:0] mem_ff [STACK_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem_ff[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rd_data_ff <= mem_ff[req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/pse_alu.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial fixed-point ALU
// Bit-serial add/sub, shift-add multiply and restoring divide, one bit per
// cycle, with saturation on the final result.
// ---------------------------------------------------------------------------
module pse_alu (
   input  logic                       clock,
   input  logic                       reset,
   input  pse_pkg::alu_cmd_type       cmd,
   input  logic [pse_pkg::WORD_W-1:0] a,
   input  logic [pse_pkg::WORD_W-1:0] b,
   output logic                       done,
   output logic [pse_pkg::WORD_W-1:0] result
);
   import pse_pkg::*;

   typedef enum logic [1:0] {
      A_IDLE,
      A_RUN,
      A_FIN
   } alu_state_type;

   function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] w);
      return w[WORD_W-1] ? (~w + WORD_W'(1)) : w;
   endfunction

   function automatic logic [WORD_W-1:0] sat_mag(input logic [WORD_W-1:0] m,
                                                 input logic big,
                                                 input logic neg);
      logic [WORD_W-1:0] r;
      if (neg) begin
         r = big ? WORD_MIN : (~m + WORD_W'(1));
      end else begin
         r = big ? WORD_MAX : m;
      end
      return r;
   endfunction

   alu_state_type     state_ff, state_in;
   op_type            op_ff, op_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] y_ff, y_in;
   logic [WORD_W-1:0] z_ff, z_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic              carry_ff, carry_in;
   logic              big_ff, big_in;
   logic              sa_ff, sa_in;
   logic              sb_ff, sb_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] result_ff, result_in;

   logic                bx, sbit;
   logic [WORD_W:0]     msum;
   logic [WORD_W:0]     rem_sh;
   logic [2*WORD_W-1:0] prod;
   logic                raw_ovf;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      rem_in    = rem_ff;
      carry_in  = carry_ff;
      big_in    = big_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      done_in   = 1'b0;
      result_in = result_ff;

      bx      = y_ff[0] ^ (op_ff == OP_SUB);
      sbit    = x_ff[0] ^ bx ^ carry_ff;
      msum    = {1'b0, z_ff} + (x_ff[0] ? {1'b0, y_ff} : '0);
      rem_sh  = {rem_ff, x_ff[WORD_W-1]};
      prod    = {z_ff, x_ff};
      raw_ovf = 1'b0;

      unique case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               sa_in    = a[WORD_W-1];
               sb_in    = b[WORD_W-1];
               z_in     = '0;
               rem_in   = '0;
               big_in   = 1'b0;
               carry_in = (cmd.op == OP_SUB);
               if (cmd.op == OP_ADD || cmd.op == OP_SUB) begin
                  x_in = a;
                  y_in = b;
               end else begin
                  x_in = mag(a);
                  y_in = mag(b);
               end
               cnt_in   = (cmd.op == OP_DIV) ? ITER_W'(NUM_W - 1) : ITER_W'(WORD_W - 1);
               state_in = A_RUN;
            end
         end
         A_RUN: begin
            case (op_ff) inside
               OP_ADD, OP_SUB: begin
                  carry_in = (x_ff[0] & bx) | (x_ff[0] & carry_ff) | (bx & carry_ff);
                  x_in     = x_ff >> 1;
                  y_in     = y_ff >> 1;
                  z_in     = {sbit, z_ff[WORD_W-1:1]};
               end
               OP_MUL: begin
                  z_in = msum[WORD_W:1];
                  x_in = {msum[0], x_ff[WORD_W-1:1]};
               end
               default: begin
                  x_in   = x_ff << 1;
                  big_in = big_ff | z_ff[WORD_W-1];
                  if (rem_sh >= {1'b0, y_ff}) begin
                     rem_in = WORD_W'(rem_sh - {1'b0, y_ff});
                     z_in   = {z_ff[WORD_W-2:0], 1'b1};
                  end else begin
                     rem_in = rem_sh[WORD_W-1:0];
                     z_in   = {z_ff[WORD_W-2:0], 1'b0};
                  end
               end
            endcase
            cnt_in = cnt_ff - ITER_W'(1);
            if (cnt_ff == '0) begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            case (op_ff)
               OP_ADD: begin
                  raw_ovf   = (sa_ff == sb_ff) && (z_ff[WORD_W-1] != sa_ff);
                  result_in = raw_ovf ? (sa_ff ? WORD_MIN : WORD_MAX) : z_ff;
               end
               OP_SUB: begin
                  raw_ovf   = (sa_ff != sb_ff) && (z_ff[WORD_W-1] != sa_ff);
                  result_in = raw_ovf ? (sa_ff ? WORD_MIN : WORD_MAX) : z_ff;
               end
               OP_MUL: begin
                  result_in = sat_mag(prod[FRAC_BITS +: WORD_W],
                                      |prod[2*WORD_W-1:WORD_W-1+FRAC_BITS],
                                      sa_ff ^ sb_ff);
               end
               default: begin
                  result_in = sat_mag(z_ff, big_ff | z_ff[WORD_W-1], sa_ff ^ sb_ff);
               end
            endcase
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      rem_ff    <= rem_in;
      carry_ff  <= carry_in;
      big_ff    <= big_in;
      sa_ff     <= sa_in;
      sb_ff     <= sb_in;
      result_ff <= result_in;
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Postfix stack evaluator testbench
// Feeds postfix expressions one character word at a time with random gaps
// and result back-pressure, and checks each result word against a fixed-point
// evaluator of the expression kept alongside the design.
// ---------------------------------------------------------------------------
module tb_top;
   import pse_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_word_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              ok;
      err_type           code;
   } answer_type;

   localparam int RUN_LIMIT_NS = 30_000_000;
   localparam int RANDOM_CHARS = 1800;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD    = 400;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_ch    = '0;
   logic               req_last  = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_value;
   logic               rsp_ok;
   logic [2:0]         rsp_error_code;

   char_word_type char_queue[$];
   logic [7:0]    expr_buf[$];
   answer_type    due_answers[$];

   logic [WORD_W-1:0] eval_stack[STACK_DEPTH];
   int unsigned       eval_depth = 0;
   err_type           eval_error = ERR_NONE;

   int words_sent   = 0;
   int answers_seen = 0;
   int cycle_n      = 0;
   int tx_idle      = 0;
   int rx_hold      = 0;
   bit failed       = 1'b0;

   postfix_stack_evaluator_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_ok         (rsp_ok),
      .rsp_error_code (rsp_error_code)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] clamp_signed(logic signed [63:0] s);
      if (s > 64'sd2147483647) return WORD_MAX;
      if (s < -64'sd2147483648) return WORD_MIN;
      return s[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] clamp_mag(logic [63:0] m, logic neg);
      logic [63:0] t;
      t = 64'd0 - m;
      if (neg) begin
         if (m >= 64'h8000_0000) return WORD_MIN;
         return t[WORD_W-1:0];
      end
      if (m > 64'h7FFF_FFFF) return WORD_MAX;
      return m[WORD_W-1:0];
   endfunction

   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // one character step; on the last word, queue the expected result
   function automatic void eval_char(logic [7:0] c, logic fin);
      logic signed [WORD_W-1:0] top_w;
      logic signed [WORD_W-1:0] nxt_w;
      logic signed [63:0]       a;
      logic signed [63:0]       b;
      logic [63:0]              ma;
      logic [63:0]              mb;
      logic [WORD_W-1:0]        r;
      logic                     neg;
      answer_type               ans;
      r = '0;
      if (eval_error == ERR_NONE) begin
         if (c >= CH_ZERO && c <= CH_NINE) begin
            if (eval_depth >= STACK_DEPTH) begin
               eval_error = ERR_OVER;
            end else begin
               r = {24'd0, c - CH_ZERO};
               eval_stack[eval_depth] = r << FRAC_BITS;
               eval_depth++;
            end
         end else if (eval_depth < 2) begin
            eval_error = ERR_UNDER;
         end else begin
            top_w = eval_stack[eval_depth - 1];
            nxt_w = eval_stack[eval_depth - 2];
            b = top_w;
            a = nxt_w;
            ma = abs64(a);
            mb = abs64(b);
            neg = (a < 0) != (b < 0);
            case (c)
               CH_ADD: r = clamp_signed(a + b);
               CH_SUB: r = clamp_signed(a - b);
               CH_MUL: r = clamp_mag((ma * mb) >> FRAC_BITS, neg);
               CH_DIV: begin
                  if (b == 0) eval_error = ERR_DIV0;
                  else r = clamp_mag((ma << FRAC_BITS) / mb, neg);
               end
               default: eval_error = ERR_BADCH;
            endcase
            if (eval_error == ERR_NONE) begin
               eval_depth--;
               eval_stack[eval_depth - 1] = r;
            end
         end
      end
      if (fin) begin
         ans.code = eval_error;
         if (ans.code == ERR_NONE && eval_depth == 0) ans.code = ERR_UNDER;
         else if (ans.code == ERR_NONE && eval_depth > 1) ans.code = ERR_LEFT;
         ans.ok = (ans.code == ERR_NONE);
         ans.value = ans.ok ? eval_stack[0] : '0;
         due_answers.push_back(ans);
         eval_depth = 0;
         eval_error = ERR_NONE;
      end
   endfunction

   function automatic void check_answer();
      answer_type want;
      if (due_answers.size() == 0) begin
         $error("result word with no expression pending: value %h ok %0d code %0d",
                rsp_value, rsp_ok, rsp_error_code);
         failed = 1'b1;
      end else begin
         want = due_answers.pop_front();
         if (rsp_value !== want.value) begin
            $error("rsp_value: expected %h, got %h", want.value, rsp_value);
            failed = 1'b1;
         end
         if (rsp_ok !== want.ok) begin
            $error("rsp_ok: expected %0d, got %0d", want.ok, rsp_ok);
            failed = 1'b1;
         end
         if (rsp_error_code !== want.code) begin
            $error("rsp_error_code: expected %0d, got %0d", want.code, rsp_error_code);
            failed = 1'b1;
         end
      end
      answers_seen++;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void emit_expr();
      char_word_type w;
      foreach (expr_buf[i]) begin
         w.ch = expr_buf[i];
         w.last = (i == expr_buf.size() - 1);
         char_queue.push_back(w);
      end
      expr_buf.delete();
   endfunction

   function automatic void queue_text(string s);
      for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
      emit_expr();
   endfunction

   function automatic logic [7:0] op_char(op_type op);
      case (op)
         OP_ADD:  return CH_ADD;
         OP_SUB:  return CH_SUB;
         OP_MUL:  return CH_MUL;
         default: return CH_DIV;
      endcase
   endfunction

   function automatic logic [7:0] rand_op();
      if ($urandom_range(0, 3) == 0) return CH_MUL;
      return op_char(op_type'($urandom_range(0, 3)));
   endfunction

   function automatic logic [7:0] rand_digit(int lo, int hi);
      logic [7:0] d;
      d = 8'($urandom_range(lo, hi));
      return CH_ZERO + d;
   endfunction

   // well-formed postfix with n_dig operands; never deeper than n_dig
   function automatic void build_expr(int unsigned n_dig, bit digits_first);
      int unsigned depth;
      int unsigned pushed;
      depth = 0;
      pushed = 0;
      while (pushed < n_dig || depth > 1) begin
         if (pushed < n_dig && (depth < 2 || digits_first || $urandom_range(0, 2) != 0)) begin
            expr_buf.push_back(rand_digit(0, 9));
            pushed++;
            depth++;
         end else begin
            expr_buf.push_back(rand_op());
            depth--;
         end
      end
   endfunction

   always @(posedge clock) begin : tx_proc
      char_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         tx_idle <= 0;
      end else begin
         if (req_valid && req_ready) eval_char(req_ch, req_last);
         if (!req_valid || req_ready) begin
            if (tx_idle != 0) begin
               req_valid <= 1'b0;
               tx_idle <= tx_idle - 1;
            end else if (char_queue.size() != 0) begin
               w = char_queue.pop_front();
               req_valid <= 1'b1;
               req_ch <= w.ch;
               req_last <= w.last;
               tx_idle <= ((words_sent / 150) % 4 == 3) ? 0 : idle_len();
               words_sent <= words_sent + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rx_proc
      int n;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_hold <= 0;
      end else begin
         cycle_n <= cycle_n + 1;
         if (rsp_valid && rsp_ready) check_answer();
         if (rx_hold != 0) begin
            rsp_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
         end else if (rsp_valid && rsp_ready && answers_seen % 80 == 10) begin
            // long hold-off: the evaluator stalls in S_OUT and backs up its input
            rsp_ready <= 1'b0;
            rx_hold <= LONG_HOLD;
         end else begin
            n = ((cycle_n / 500) % 4 == 1) ? 0 : idle_len();
            rsp_ready <= (n == 0);
            rx_hold <= (n == 0) ? 0 : n - 1;
         end
      end
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("** postfix_stack_evaluator_top: FAILED **");
      $finish;
   end

   initial begin : run_ctl
      int base;
      int pick;
      int idx;
      queue_text("9");
      queue_text("12+");
      queue_text("18-");
      queue_text("97*");
      queue_text("72/");
      queue_text("30/");
      queue_text("+");
      queue_text("12a");
      queue_text("12");
      queue_text("1a");
      expr_buf.push_back(8'h00);
      emit_expr();
      expr_buf.push_back(8'hFF);
      emit_expr();

      base = char_queue.size();
      while (char_queue.size() - base < RANDOM_CHARS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            build_expr($urandom_range(1, 10), 1'b0);
         end else if (pick < 63) begin
            build_expr($urandom_range(11, 32), 1'($urandom_range(0, 1)));
         end else if (pick < 68) begin
            build_expr(STACK_DEPTH, 1'b1);
         end else if (pick < 72) begin
            build_expr(STACK_DEPTH + 1 + $urandom_range(0, 3), 1'b1);
         end else if (pick < 80) begin
            // multiply chain from 9 or -9 that can run into saturation, then one more op
            if ($urandom_range(0, 1) == 1) begin
               expr_buf.push_back(CH_ZERO);
               expr_buf.push_back(CH_NINE);
               expr_buf.push_back(CH_SUB);
            end else begin
               expr_buf.push_back(CH_NINE);
            end
            repeat ($urandom_range(3, 6)) begin
               expr_buf.push_back(rand_digit(7, 9));
               expr_buf.push_back(CH_MUL);
            end
            expr_buf.push_back(rand_digit(0, 9));
            expr_buf.push_back(rand_op());
         end else if (pick < 88) begin
            build_expr($urandom_range(2, 10), 1'b0);
            case ($urandom_range(0, 2))
               0: begin
                  idx = $urandom_range(0, expr_buf.size() - 1);
                  expr_buf[idx] = 8'($urandom_range(0, 255));
               end
               1: expr_buf.delete(expr_buf.size() - 1);
               default: expr_buf.push_back(rand_op());
            endcase
         end else begin
            repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
         end
         emit_expr();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (char_queue.size() != 0 || req_valid) @(negedge clock);
      while (due_answers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (!failed) begin
         $display("** postfix_stack_evaluator_top: PASSED **");
      end else begin
         $display("** postfix_stack_evaluator_top: FAILED **");
      end
      $finish;
   end

endmodule

@@ postfix_stack_evaluator_top.f @@
src/pse_pkg.sv
src/pse_stack.sv
src/pse_alu.sv
src/postfix_stack_evaluator_top.sv
sim/tb_top.sv
